// ===== hdl/b64u_pkg.sv =====
package b64u_pkg;

  localparam int B64U_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [23:0] bytes;
    logic        last;
  } b64u_group_t;

  function automatic logic [7:0] b64u_char(input logic [5:0] sextet);
    logic [7:0] wide;
    wide = {2'b00, sextet};
    if (sextet < 6'd26) begin
      return wide + 8'd65;
    end else if (sextet < 6'd52) begin
      return wide + 8'd71;
    end else if (sextet < 6'd62) begin
      return wide - 8'd4;
    end else if (sextet == 6'd62) begin
      return 8'd45;
    end else begin
      return 8'd95;
    end
  endfunction

endpackage

// ===== hdl/b64u_front.sv =====
module b64u_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // data_byte
  input  logic                  s_tlast,   // last_byte
  output logic                  grp_valid,
  input  logic                  grp_ready,
  output b64u_pkg::b64u_group_t grp
);
  import b64u_pkg::*;

  logic [15:0] held;
  logic [1:0]  cnt;
  logic        accept;
  logic        close;

  assign s_tready  = grp_ready;
  assign accept    = s_tvalid && s_tready;
  assign close     = (cnt == 2'd2) || s_tlast;
  assign grp_valid = accept && close;

  always_comb begin
    grp.last = s_tlast;
    case (cnt)
      2'd0:    grp.bytes = {s_tdata, 16'h0000};
      2'd1:    grp.bytes = {held[7:0], s_tdata, 8'h00};
      default: grp.bytes = {held, s_tdata};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      cnt  <= '0;
    end else if (accept) begin
      if (close) begin
        held <= '0;
        cnt  <= '0;
      end else begin
        held <= {held[7:0], s_tdata};
        cnt  <= cnt + 2'd1;
      end
    end
  end

endmodule

// ===== hdl/b64u_queue.sv =====
module b64u_queue #(
  parameter int DEPTH = b64u_pkg::B64U_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  b64u_pkg::b64u_group_t in_grp,
  output logic                  out_valid,
  input  logic                  out_ready,
  output b64u_pkg::b64u_group_t out_grp
);
  import b64u_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64u_group_t    slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_ready  = count != CW'(DEPTH);
  assign out_valid = count != '0;
  assign out_grp   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/b64u_back.sv =====
module b64u_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  grp_valid,
  output logic                  grp_ready,
  input  b64u_pkg::b64u_group_t grp,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_char
  output logic                  m_tlast,   // run_last
  output logic                  m_tuser    // message_end
);
  import b64u_pkg::*;

  b64u_group_t cur;
  logic        busy;
  logic [1:0]  idx;
  logic        advance;
  logic        emit;
  logic        load;
  logic [5:0]  sextet;

  assign advance   = !m_tvalid || m_tready;
  assign emit      = busy && advance;
  assign grp_ready = !busy || (emit && idx == 2'd3);
  assign load      = grp_valid && grp_ready;

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.bytes[23:18];
      2'd1:    sextet = cur.bytes[17:12];
      2'd2:    sextet = cur.bytes[11:6];
      default: sextet = cur.bytes[5:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= grp;
    end
    if (emit) begin
      m_tdata <= b64u_char(sextet);
      m_tlast <= idx == 2'd3;
      m_tuser <= (idx == 2'd3) && cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_tvalid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/base64url_stream_encoder_unit.sv =====
// Path: a byte that closes a group is registered in the queue, then in the back
// end's current group, then in the output character register. Throughput: one
// character per cycle while the output is not stalled, set by the back end's
// character stage; a byte a cycle enters while the group queue has room.
// Reset: synchronous, active high; clears the partial group, the queue and the output.
module base64url_stream_encoder_unit #(
  parameter int QUEUE_DEPTH = b64u_pkg::B64U_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // message_end
);
  import b64u_pkg::*;

  b64u_group_t front_grp;
  b64u_group_t back_grp;
  logic        front_valid;
  logic        front_ready;
  logic        back_valid;
  logic        back_ready;

  b64u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .grp_valid (front_valid),
    .grp_ready (front_ready),
    .grp       (front_grp)
  );

  b64u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_grp    (front_grp),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_grp   (back_grp)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (back_valid),
    .grp_ready (back_ready),
    .grp       (back_grp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BYTES = 408;
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       group_end;
    logic       msg_end;
  } char_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  raw_beat_t  tx_bytes[$];
  char_beat_t expected_chars[$];

  logic [15:0] held_bytes = 16'h0000;
  logic [1:0]  held_count = 2'd0;

  int errors = 0;
  int chars_seen = 0;
  int messages_queued = 0;
  int bytes_queued = 0;
  int cycles = 0;

  base64url_stream_encoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] url_char(input logic [5:0] sextet);
    return URL_ALPHABET[8*(63 - int'(sextet)) +: 8];
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [23:0] grp;
    char_beat_t  beat;
    if (held_count < 2'd2 && !last) begin
      held_bytes = {held_bytes[7:0], b};
      held_count = held_count + 2'd1;
    end else begin
      case (held_count)
        2'd0: begin
          grp = {b, 16'h0000};
        end
        2'd1: begin
          grp = {held_bytes[7:0], b, 8'h00};
        end
        default: begin
          grp = {held_bytes, b};
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        beat.ch = url_char(grp[23-6*k -: 6]);
        beat.group_end = (k == 3);
        beat.msg_end = (k == 3) && last;
        expected_chars.push_back(beat);
      end
      held_bytes = 16'h0000;
      held_count = 2'd0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    raw_beat_t r;
    r.data = b;
    r.last = last;
    tx_bytes.push_back(r);
    bytes_queued++;
    if (last) begin
      messages_queued++;
    end
  endtask

  task automatic queue_random_message(input int len);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // drive input beats; hold steady through a window with no idling
  always @(posedge clk) begin : drive_bytes
    raw_beat_t nxt;
    logic      steady;
    steady = (tx_bytes.size() > 100) && (tx_bytes.size() < 220);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_byte(s_tdata, s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (tx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
          nxt = tx_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tlast <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // check output beats against the oldest expected character
  always @(posedge clk) begin : check_chars
    char_beat_t want;
    logic       steady;
    steady = (chars_seen > 150) && (chars_seen < 350);
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("ERROR: unexpected char %02h tlast=%b tuser=%b",
                     m_tdata, m_tlast, m_tuser);
          end
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.ch || m_tlast !== want.group_end || m_tuser !== want.msg_end)
          begin
            errors++;
            if (errors <= 10) begin
              $display("ERROR: char %0d expected %02h/%b/%b got %02h/%b/%b",
                       chars_seen, want.ch, want.group_end, want.msg_end,
                       m_tdata, m_tlast, m_tuser);
            end
          end
        end
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // single-byte messages at the extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // two-byte message, one zero byte filled in
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // full groups: all ones, all minus signs, all zeros
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hFB, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hBE, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // group closed by count, then a trailing partial group
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h04, 1'b1);
    // five bytes spanning upper case, lower case, digit and underscore characters
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h3F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hC0, 1'b1);
    while (bytes_queued < RANDOM_BYTES + 22) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_random_message($urandom_range(20, 40));
      end else begin
        queue_random_message($urandom_range(1, 9));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (tx_bytes.size() != 0 || s_tvalid) begin
      @(posedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d messages, %0d bytes in; checked %0d characters out.",
             messages_queued, bytes_queued, chars_seen);
    $display("Mismatches: %0d, characters still expected: %0d",
             errors, expected_chars.size());
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
